>>> src/pft_pkg.sv
// ----------------------------------------------------------------------------
// pft_pkg
// Shared constants, codes and structs for the prime flag table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package pft_pkg;

    localparam int TABLE_SIZE = 4096;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    // trial divisors never exceed the first odd value above sqrt(TABLE_SIZE)
    localparam int DIV_W      = (ADDR_W + 1) / 2 + 1;
    localparam int SQ_W       = 2 * DIV_W;
    localparam int CNT_W      = $clog2(ADDR_W);

    localparam logic [ADDR_W-1:0] FIRST_ODD = ADDR_W'(3);
    localparam logic [ADDR_W-1:0] LAST_N    = ADDR_W'(TABLE_SIZE - 1);
    localparam logic [DIV_W-1:0]  DIV_FIRST = DIV_W'(3);
    localparam logic [DIV_W-1:0]  DIV_STEP  = DIV_W'(2);

    localparam logic       CMD_BUILD = 1'b0;
    localparam logic       CMD_QUERY = 1'b1;

    localparam logic [1:0] ST_ANSWERED  = 2'd0;
    localparam logic [1:0] ST_BUILT     = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_stat;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
        logic [DIV_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic zero;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> src/prime_flag_table_builder.sv
// ----------------------------------------------------------------------------
// prime_flag_table_builder
// Prime flag table: build by trial division into a flag memory, then
// answer single-number queries from it.
// ----------------------------------------------------------------------------
//  channel | signals                                 | moves
//  --------+-----------------------------------------+--------------------------
//  in      | i_in_valid, o_in_ready, i_cmd, i_number | one command per transfer
//  out     | o_out_valid, i_out_ready, o_prime_flag, | one result per command
//          | o_status                                |
//
//  Queries: one per cycle while no build runs and the output is not stalled;
//  the read data registers at the transfer edge and then feeds the output slot.
//  Build: an even n is written straight away, a skipped divisor costs one flag
//  read, a flagged divisor tried runs the serial remainder unit, which dominates.
//  Reset clears control and the built flag; the table is garbage until built.
//  A stalled output holds the query in the read stage and drops o_in_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_flag_table_builder
    import pft_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  wire              i_cmd,
    input  wire [ADDR_W-1:0] i_number,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output logic             o_prime_flag,
    output logic [1:0]       o_status
);

    t_ram_req  seq_ram_req;
    t_ram_req  ram_req;
    t_div_req  div_req;
    t_div_rsp  div_rsp;
    t_seq_stat seq_stat;
    logic      rdata;

    logic r_built;
    logic r_q_vld;
    logic r_q_built;
    logic r_out_vld;
    logic r_out_flag;
    logic [1:0] r_out_status;

    logic out_free;
    logic q_adv;
    logic accept;
    logic q_accept;
    logic build_start;
    logic build_ack;

    // output slot can take new data this cycle
    assign out_free    = !r_out_vld || i_out_ready;
    assign q_adv       = r_q_vld && out_free;
    assign o_in_ready  = !seq_stat.busy && (!r_q_vld || out_free);
    assign accept      = i_in_valid && o_in_ready;
    assign q_accept    = accept && (i_cmd == CMD_QUERY);
    assign build_start = accept && (i_cmd == CMD_BUILD);
    assign build_ack   = seq_stat.done && out_free;

    // the sequencer is idle whenever a query is taken
    always_comb begin
        ram_req = seq_ram_req;
        if (q_accept) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = i_number;
        end
    end

    pft_flag_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    pft_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    pft_build_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (build_start),
        .i_ack     (build_ack),
        .i_rdata   (rdata),
        .i_div_rsp (div_rsp),
        .o_div_req (div_req),
        .o_ram_req (seq_ram_req),
        .o_stat    (seq_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_built   <= 1'b0;
            r_q_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (q_accept) begin
                r_q_vld <= 1'b1;
            end else if (q_adv) begin
                r_q_vld <= 1'b0;
            end

            if (q_adv || build_ack) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            if (build_ack) begin
                r_built <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_accept) begin
            r_q_built <= r_built;
        end
        if (q_adv) begin
            // unbuilt table reads are masked
            r_out_flag   <= r_q_built & rdata;
            r_out_status <= r_q_built ? ST_ANSWERED : ST_NOT_BUILT;
        end else if (build_ack) begin
            r_out_flag   <= 1'b0;
            r_out_status <= ST_BUILT;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_prime_flag = r_out_flag;
    assign o_status     = r_out_status;

endmodule

`default_nettype wire

>>> src/pft_flag_ram.sv
// ----------------------------------------------------------------------------
// pft_flag_ram
// One-bit flag memory, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pft_flag_ram
    import pft_pkg::*;
(
    input  wire  i_clk,
    input  t_ram_req i_req,
    output logic o_rdata
);

    logic r_mem [TABLE_SIZE];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/pft_mod_unit.sv
// ----------------------------------------------------------------------------
// pft_mod_unit
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pft_mod_unit
    import pft_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ADDR_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [ADDR_W-1:0] r_num;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_rem;

    logic [DIV_W:0]    trial;
    logic [DIV_W-1:0]  diff;
    logic [DIV_W-1:0]  n_rem;

    // when trial >= divisor the difference is below the divisor, so it fits
    always_comb begin
        trial = {r_rem, r_num[ADDR_W-1]};
        diff  = trial[DIV_W-1:0] - r_div;
        n_rem = (trial >= {1'b0, r_div}) ? diff : trial[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[ADDR_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = (r_rem == '0);

endmodule

`default_nettype wire

>>> src/pft_build_seq.sv
// ----------------------------------------------------------------------------
// pft_build_seq
// Build sequencer: walks n over the table, trial-divides odd n by flagged
// odd divisors read back from the flag memory, writes each flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pft_build_seq
    import pft_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_start,
    input  wire       i_ack,
    input  wire       i_rdata,
    input  t_div_rsp  i_div_rsp,
    output t_div_req  o_div_req,
    output t_ram_req  o_ram_req,
    output t_seq_stat o_stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NEXT  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_FLAG  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_n, n_n;
    logic [DIV_W-1:0]  r_i, n_i;
    logic [SQ_W-1:0]   sq;
    logic              wr;
    logic              wr_val;

    assign sq = SQ_W'(r_i) * SQ_W'(r_i);

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_i       = r_i;
        wr        = 1'b0;
        wr_val    = 1'b0;
        o_ram_req = '0;
        o_div_req = '0;
        o_div_req.dividend = r_n;
        o_div_req.divisor  = r_i;
        o_stat.busy = (r_state != S_IDLE);
        o_stat.done = (r_state == S_DONE);

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_n     = '0;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_n < FIRST_ODD) begin
                    wr     = 1'b1;
                    wr_val = (r_n != '0);   // 1 and 2 are flagged
                end else if (!r_n[0]) begin
                    wr     = 1'b1;
                end else begin
                    n_i     = DIV_FIRST;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sq > SQ_W'(r_n)) begin
                    wr     = 1'b1;
                    wr_val = 1'b1;
                end else begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = ADDR_W'(r_i);
                    n_state         = S_FLAG;
                end
            end
            S_FLAG: begin
                if (i_rdata) begin
                    o_div_req.start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_i     = r_i + DIV_STEP;
                    n_state = S_CHECK;
                end
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    if (i_div_rsp.zero) begin
                        wr = 1'b1;
                    end else begin
                        n_i     = r_i + DIV_STEP;
                        n_state = S_CHECK;
                    end
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // flag written: move to next n or finish
        if (wr) begin
            o_ram_req.we    = 1'b1;
            o_ram_req.waddr = r_n;
            o_ram_req.wdata = wr_val;
            n_n             = r_n + 1'b1;
            n_state         = (r_n == LAST_N) ? S_DONE : S_NEXT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;
        r_i <= n_i;
    end

endmodule

`default_nettype wire
